// File: rtl/dqbf_pkg.sv
`timescale 1ns / 1ps
package dqbf_pkg;

  localparam int unsigned MAX_ENTRIES  = 64;
  localparam int unsigned NAME_BYTES   = 256;
  localparam int unsigned MAX_PACKET   = 512;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam int unsigned ENT_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned POS_W  = $clog2(NAME_BYTES);
  localparam int unsigned LEN_W  = POS_W + 1;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned FPTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W = FPTR_W + 1;

  // input kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PKT  = 1'b1;

  // result actions
  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_PATCH   = 2'd1;
  localparam logic [1:0] ACT_REPLY   = 2'd2;

  // response types
  localparam logic [1:0] RT_REFUSED  = 2'd2;
  localparam logic [1:0] RT_REDIRECT = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_RESP_TYPE = 2'd0;
  localparam logic [1:0] REG_REDIR_IP  = 2'd1;
  localparam logic [1:0] REG_ENT_COUNT = 2'd2;

  localparam logic [7:0] DOT_CHAR      = 8'h2e;
  localparam logic [7:0] FLAGS_HI      = 8'h81;
  localparam logic [7:0] FLAGS_LO      = 8'h80;
  localparam logic [7:0] FLAGS_LO_REF  = 8'h85;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_NAME     = 4'b0010,
    PH_NAME_CUT = 4'b0100,
    PH_TAIL     = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_CMP    = 2'd1,
    OP_ENDCHK = 2'd2
  } op_e;

  // compare operation handed from the parser to the match stage
  typedef struct packed {
    logic             valid;
    op_e              kind;
    logic [7:0]       ch;
    logic             last;
    logic             elig;
    logic [OFF_W-1:0] qend;
  } cmp_op_t;

  // verdict handed to the reply sequencer
  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] qend;
  } verdict_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  // answer record template
  function automatic logic [7:0] answer_byte(input logic [3:0] i);
    case (i)
      4'd0:    answer_byte = 8'hc0;
      4'd1:    answer_byte = 8'h0c;
      4'd3:    answer_byte = 8'h01;
      4'd5:    answer_byte = 8'h01;
      4'd9:    answer_byte = 8'h3c;
      4'd11:   answer_byte = 8'h04;
      default: answer_byte = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/dqbf_ram.sv
`timescale 1ns / 1ps
module dqbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dqbf_front.sv
`timescale 1ns / 1ps
module dqbf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  cmd_i,
  input  logic [7:0]            data_i,
  input  logic                  last_i,
  output dqbf_pkg::cmp_op_t     op_o,
  output logic [dqbf_pkg::POS_W-1:0] rd_pos_o
);
  import dqbf_pkg::*;

  logic [OFF_W-1:0] off_q, off_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       lrem_q, lrem_d;
  logic [LEN_W-1:0] nlen_q, nlen_d;
  logic             ovf_q, ovf_d;
  logic [OFF_W-1:0] qend_q, qend_d;
  logic             nc_en;
  logic [7:0]       nc_val;
  cmp_op_t          op;
  logic [POS_W-1:0] pos;

  // label walk and name rebuild
  always_comb begin
    off_d   = off_q;
    phase_d = phase_q;
    lrem_d  = lrem_q;
    nlen_d  = nlen_q;
    ovf_d   = ovf_q;
    qend_d  = qend_q;
    nc_en   = 1'b0;
    nc_val  = data_i;
    op      = '0;
    op.kind = OP_NONE;
    pos     = nlen_q[POS_W-1:0];
    if (accept_i && cmd_i == CMD_PKT && off_q < OFF_W'(MAX_PACKET)) begin
      off_d = off_q + 1'b1;
      case (phase_q)
        PH_HEADER: begin
          if (off_q >= OFF_W'(HEADER_BYTES - 1)) begin
            phase_d = PH_NAME;
          end
        end
        PH_NAME, PH_NAME_CUT: begin
          if (lrem_q == 8'd0) begin
            if (data_i == 8'd0) begin
              if (phase_q == PH_NAME && !ovf_q) begin
                op.kind = OP_ENDCHK;
              end
              qend_d  = off_q;
              phase_d = PH_TAIL;
            end else begin
              nc_en  = (nlen_q != '0);
              nc_val = DOT_CHAR;
              lrem_d = data_i;
            end
          end else begin
            nc_en  = 1'b1;
            lrem_d = lrem_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
      // one name character
      if (nc_en) begin
        if (nlen_q >= LEN_W'(NAME_BYTES - 1)) begin
          ovf_d = 1'b1;
        end else begin
          if (phase_q == PH_NAME) begin
            op.kind = OP_CMP;
            op.ch   = nc_val;
            if (nc_val == 8'd0) begin
              phase_d = PH_NAME_CUT;
            end
          end
          nlen_d = nlen_q + 1'b1;
        end
      end
    end
    op.valid = accept_i;
    op.last  = last_i;
    op.elig  = (phase_d == PH_TAIL) && !ovf_d;
    op.qend  = qend_d;
    // packet end returns to the idle state
    if (accept_i && last_i) begin
      off_d   = '0;
      phase_d = PH_HEADER;
      lrem_d  = '0;
      nlen_d  = '0;
      ovf_d   = 1'b0;
      qend_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      phase_q <= PH_HEADER;
      lrem_q  <= '0;
      nlen_q  <= '0;
      ovf_q   <= 1'b0;
      qend_q  <= '0;
    end else begin
      off_q   <= off_d;
      phase_q <= phase_d;
      lrem_q  <= lrem_d;
      nlen_q  <= nlen_d;
      ovf_q   <= ovf_d;
      qend_q  <= qend_d;
    end
  end

  assign op_o     = op;
  assign rd_pos_o = pos;

endmodule

// File: rtl/dqbf_match.sv
`timescale 1ns / 1ps
module dqbf_match (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dqbf_pkg::cmp_op_t          op_i,
  input  logic [dqbf_pkg::POS_W-1:0] rd_pos_i,
  input  logic                       ld_we_i,
  input  logic [dqbf_pkg::ENT_W-1:0] ld_ent_i,
  input  logic [dqbf_pkg::POS_W-1:0] ld_pos_i,
  input  logic [7:0]                 ld_data_i,
  input  logic [dqbf_pkg::CNT_W-1:0] entry_count_i,
  output logic                       pending_o,
  output logic                       push_o,
  output dqbf_pkg::verdict_t         verdict_o
);
  import dqbf_pkg::*;

  logic [7:0]             rdata [MAX_ENTRIES];
  cmp_op_t                st_q;
  logic [MAX_ENTRIES-1:0] flags_q, flags_d, flags_n, mask;

  // one byte lane of the blacklist per entry
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_lane
    dqbf_ram #(
      .WIDTH(8),
      .DEPTH(NAME_BYTES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ld_we_i && ld_ent_i == ENT_W'(g)),
      .waddr_i(ld_pos_i),
      .wdata_i(ld_data_i),
      .raddr_i(rd_pos_i),
      .rdata_o(rdata[g])
    );
  end

  // compare stage lines up with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= op_i;
    end
  end

  // per entry match update
  always_comb begin
    flags_n = flags_q;
    for (int e = 0; e < MAX_ENTRIES; e++) begin
      mask[e] = CNT_W'(e) < entry_count_i;
      if (st_q.valid && st_q.kind == OP_CMP && fold(rdata[e]) != fold(st_q.ch)) begin
        flags_n[e] = 1'b0;
      end
      if (st_q.valid && st_q.kind == OP_ENDCHK && rdata[e] != 8'd0) begin
        flags_n[e] = 1'b0;
      end
    end
    push_o         = st_q.valid && st_q.last;
    verdict_o.hit  = st_q.elig && |(flags_n & mask);
    verdict_o.qend = st_q.qend;
    flags_d        = push_o ? '1 : flags_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '1;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign pending_o = st_q.valid && st_q.last;

endmodule

// File: rtl/dqbf_back.sv
`timescale 1ns / 1ps
module dqbf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  dqbf_pkg::verdict_t          verdict_i,
  input  logic                        pending_i,
  output logic                        room_o,
  input  logic [1:0]                  response_type_i,
  input  logic [31:0]                 redirect_ip_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [1:0]                  m_action_o,
  output logic [dqbf_pkg::OFF_W-1:0]  m_offset_o,
  output logic [7:0]                  m_value_o,
  output logic                        m_end_o
);
  import dqbf_pkg::*;

  verdict_t          fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] rd_q, wr_q;
  logic [FCNT_W-1:0] cnt_q;
  logic [4:0]        k_q, k_d;
  verdict_t          head;
  logic              gen_valid, load, pop, final_w, rt3;
  logic [1:0]        g_act;
  logic [OFF_W-1:0]  g_off;
  logic [7:0]        g_val;
  logic              out_vld_q;
  logic [1:0]        act_q;
  logic [OFF_W-1:0]  off_q;
  logic [7:0]        val_q;
  logic              end_q;

  assign head      = fifo_q[rd_q];
  assign gen_valid = cnt_q != '0;
  assign load      = gen_valid && (!out_vld_q || m_ready_i);
  assign pop       = load && final_w;
  assign rt3       = response_type_i == RT_REDIRECT;
  assign room_o    = (cnt_q + FCNT_W'(pending_i)) < FCNT_W'(FIFO_DEPTH);

  // verdict queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + FCNT_W'(push_i) - FCNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_q] <= verdict_i;
    end
  end

  // reply sequence generator
  always_comb begin
    g_act   = ACT_PATCH;
    g_off   = '0;
    g_val   = '0;
    final_w = 1'b0;
    if (!head.hit) begin
      g_act   = ACT_FORWARD;
      final_w = 1'b1;
    end else if (k_q == 5'd0) begin
      g_off = OFF_W'(2);
      g_val = FLAGS_HI;
    end else if (k_q == 5'd1) begin
      g_off = OFF_W'(3);
      g_val = (response_type_i == RT_REFUSED) ? FLAGS_LO_REF : FLAGS_LO;
    end else if (k_q < 5'd8) begin
      g_off = OFF_W'(k_q) + OFF_W'(4);
      g_val = (k_q == 5'd3 && rt3) ? 8'd1 : 8'd0;
    end else if (!rt3) begin
      g_act   = ACT_REPLY;
      g_off   = head.qend + OFF_W'(5);
      final_w = 1'b1;
    end else if (k_q < 5'd20) begin
      g_off = head.qend + OFF_W'(k_q) - OFF_W'(3);
      g_val = answer_byte(4'(k_q - 5'd8));
    end else if (k_q < 5'd24) begin
      g_off = head.qend + OFF_W'(k_q) - OFF_W'(3);
      case (k_q[1:0])
        2'd0:    g_val = redirect_ip_i[31:24];
        2'd1:    g_val = redirect_ip_i[23:16];
        2'd2:    g_val = redirect_ip_i[15:8];
        default: g_val = redirect_ip_i[7:0];
      endcase
    end else begin
      g_act   = ACT_REPLY;
      g_off   = head.qend + OFF_W'(21);
      final_w = 1'b1;
    end
    k_d = k_q;
    if (load) begin
      k_d = final_w ? 5'd0 : k_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q <= g_act;
      off_q <= g_off;
      val_q <= g_val;
      end_q <= final_w;
    end
  end

  assign m_valid_o  = out_vld_q;
  assign m_action_o = act_q;
  assign m_offset_o = off_q;
  assign m_value_o  = val_q;
  assign m_end_o    = end_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FCNT_W'(FIFO_DEPTH)) else $error("verdict queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty verdict queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < FCNT_W'(FIFO_DEPTH)) || pop) else $error("push into full queue");
  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 5'd24) else $error("reply sequence overran");

endmodule

// File: rtl/dns_query_blacklist_filter.sv
`timescale 1ns / 1ps
// a packet's verdict passes the compare stage register, then the verdict queue, then the output register
// throughput: one input word per cycle while s_axis_tready is high; the parser never waits on the blacklist read
// results leave at one per cycle while m_axis_tready is high: 1 for a forwarded packet, 9 or 25 for a blocked one
// input stalls while four verdicts are queued or about to enter the queue
// reset: asynchronous, active low; clears parse state, match flags, queue and config registers
module dns_query_blacklist_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // entry_index[5:0], char_position[13:6], data_byte[21:14]
  input  logic [0:0]  s_axis_tuser,  // cmd[0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // offset[9:0], value[17:10]
  output logic [1:0]  m_axis_tuser,  // action[1:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dqbf_pkg::*;

  logic [1:0]       resp_type_q;
  logic [31:0]      redir_ip_q;
  logic [CNT_W-1:0] ent_cnt_q;
  logic             accept, room, pending, push, cfg_we;
  cmp_op_t          op;
  logic [POS_W-1:0] rd_pos;
  verdict_t         verdict;
  logic [1:0]       m_act;
  logic [OFF_W-1:0] m_off;
  logic [7:0]       m_val;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // config registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_type_q <= 2'd1;
      redir_ip_q  <= '0;
      ent_cnt_q   <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_RESP_TYPE: resp_type_q <= pwdata[1:0];
        REG_REDIR_IP:  redir_ip_q  <= pwdata;
        REG_ENT_COUNT: ent_cnt_q   <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RESP_TYPE: prdata = {30'd0, resp_type_q};
      REG_REDIR_IP:  prdata = redir_ip_q;
      REG_ENT_COUNT: prdata = {{(32 - CNT_W){1'b0}}, ent_cnt_q};
      default:       prdata = '0;
    endcase
  end

  dqbf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (s_axis_tuser[0]),
    .data_i  (s_axis_tdata[21:14]),
    .last_i  (s_axis_tlast),
    .op_o    (op),
    .rd_pos_o(rd_pos)
  );

  dqbf_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .rd_pos_i     (rd_pos),
    .ld_we_i      (accept && s_axis_tuser[0] == CMD_LOAD),
    .ld_ent_i     (s_axis_tdata[5:0]),
    .ld_pos_i     (s_axis_tdata[13:6]),
    .ld_data_i    (s_axis_tdata[21:14]),
    .entry_count_i(ent_cnt_q),
    .pending_o    (pending),
    .push_o       (push),
    .verdict_o    (verdict)
  );

  dqbf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .verdict_i      (verdict),
    .pending_i      (pending),
    .room_o         (room),
    .response_type_i(resp_type_q),
    .redirect_ip_i  (redir_ip_q),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_action_o     (m_act),
    .m_offset_o     (m_off),
    .m_value_o      (m_val),
    .m_end_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, m_val, m_off};
  assign m_axis_tuser = m_act;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dqbf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned FILL_ENTRIES = 4;
  localparam int unsigned FILL_CHARS   = 8;

  // kinds of directed packet
  typedef enum int {
    K_NAME, K_OPEN, K_ZERO_IN, K_SHORT, K_LOAD_MID, K_LOAD_LAST
  } pkt_kind_e;

  typedef struct {
    pkt_kind_e  kind;
    string      name;
    bit         known;
    logic [1:0] want_act;
  } pkt_row_t;

  typedef struct {
    logic [1:0]       action;
    logic [OFF_W-1:0] offset;
    logic [7:0]       value;
    logic             eor;
  } patch_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dns_query_blacklist_filter uut (.*);

  // filter shadow state
  logic [7:0]       bl_store [MAX_ENTRIES][NAME_BYTES];
  logic [OFF_W-1:0] sh_off;
  phase_e           sh_phase;
  logic [7:0]       sh_label;
  logic [LEN_W-1:0] sh_nlen;
  logic             sh_ovf;
  logic             sh_match [MAX_ENTRIES];
  logic [OFF_W-1:0] sh_qend;
  logic [1:0]       cfg_rtype;
  logic [31:0]      cfg_ip;
  logic [CNT_W-1:0] cfg_count;
  logic [1:0]       last_first_act;

  patch_t patch_q [$];
  string  ent_name [MAX_ENTRIES];
  int     errors;
  int     words_in;
  int     words_out;
  int     blocked_pkts;
  int     cycles;
  bit     idle_on;
  int     hold_req;
  int     hold_seen;
  int     hold_cnt;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] answer_tmpl(input int i);
    logic [7:0] t [12] = '{8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01,
                           8'h00, 8'h00, 8'h00, 8'h3c, 8'h00, 8'h04};
    return t[i];
  endfunction

  task automatic pkt_clear();
    sh_off   = '0;
    sh_phase = PH_HEADER;
    sh_label = '0;
    sh_nlen  = '0;
    sh_ovf   = 1'b0;
    sh_qend  = '0;
    foreach (sh_match[e]) sh_match[e] = 1'b1;
  endtask

  task automatic name_char(input logic [7:0] c);
    if (sh_nlen >= NAME_BYTES - 1) begin
      sh_ovf = 1'b1;
      return;
    end
    if (sh_phase == PH_NAME) begin
      for (int e = 0; e < MAX_ENTRIES; e++)
        if (lower(bl_store[e][sh_nlen]) != lower(c)) sh_match[e] = 1'b0;
      if (c == 8'h00) sh_phase = PH_NAME_CUT;
    end
    sh_nlen = sh_nlen + 1'b1;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    if (sh_off >= MAX_PACKET) return;
    if (sh_phase == PH_HEADER) begin
      if (sh_off + 1 >= HEADER_BYTES) sh_phase = PH_NAME;
    end else if (sh_phase != PH_TAIL) begin
      if (sh_label == 0) begin
        if (b == 0) begin
          // closing zero length: entries must end here too
          if (sh_phase == PH_NAME && !sh_ovf)
            for (int e = 0; e < MAX_ENTRIES; e++)
              if (bl_store[e][sh_nlen] != 8'h00) sh_match[e] = 1'b0;
          sh_qend  = sh_off;
          sh_phase = PH_TAIL;
        end else begin
          if (sh_nlen > 0) name_char(DOT_CHAR);
          sh_label = b;
        end
      end else begin
        name_char(b);
        sh_label = sh_label - 1'b1;
      end
    end
    sh_off = sh_off + 1'b1;
  endtask

  task automatic push_patch(input logic [1:0] a, input int off, input logic [7:0] v,
                            input logic eor);
    patch_t p;
    p.action = a;
    p.offset = off[OFF_W-1:0];
    p.value  = v;
    p.eor    = eor;
    patch_q.push_back(p);
  endtask

  task automatic give_verdict();
    int  n;
    int  pos;
    bit  hit;
    n   = (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_count;
    hit = 1'b0;
    if (sh_phase == PH_TAIL && !sh_ovf)
      for (int e = 0; e < n; e++) if (sh_match[e]) hit = 1'b1;
    if (!hit) begin
      last_first_act = ACT_FORWARD;
      push_patch(ACT_FORWARD, 0, 8'h00, 1'b1);
      return;
    end
    blocked_pkts++;
    last_first_act = ACT_PATCH;
    push_patch(ACT_PATCH, 2, FLAGS_HI, 1'b0);
    push_patch(ACT_PATCH, 3, (cfg_rtype == RT_REFUSED) ? FLAGS_LO_REF : FLAGS_LO, 1'b0);
    for (int p = 6; p < 12; p++)
      push_patch(ACT_PATCH, p, (p == 7 && cfg_rtype == RT_REDIRECT) ? 8'h01 : 8'h00, 1'b0);
    pos = sh_qend + 5;
    if (cfg_rtype == RT_REDIRECT) begin
      for (int i = 0; i < 12; i++) begin
        push_patch(ACT_PATCH, pos, answer_tmpl(i), 1'b0);
        pos++;
      end
      for (int i = 0; i < 4; i++) begin
        push_patch(ACT_PATCH, pos, cfg_ip[31-8*i -: 8], 1'b0);
        pos++;
      end
    end
    push_patch(ACT_REPLY, pos, 8'h00, 1'b1);
  endtask

  task automatic filter_step(input logic cmd, input logic [5:0] ent, input logic [7:0] cpos,
                             input logic [7:0] b, input logic last);
    if (cmd == CMD_LOAD) bl_store[ent][cpos] = b;
    else parse_byte(b);
    if (last) begin
      give_verdict();
      pkt_clear();
    end
  endtask

  task automatic check_act(input string what, input logic [1:0] want);
    if (last_first_act !== want) begin
      errors++;
      $display("%0t %s: expected action %0d actual %0d", $time, what, want, last_first_act);
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t timeout with %0d results outstanding", $time, patch_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result receiver: random idling plus a requested long hold-off
  initial begin
    m_axis_tready = 1'b0;
    hold_seen     = 0;
    hold_cnt      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    patch_t p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (patch_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word: act %0d off %0d val %h eor %b", $time,
                 m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[17:10], m_axis_tlast);
      end else begin
        p = patch_q.pop_front();
        if (m_axis_tuser !== p.action) begin
          errors++;
          $display("%0t action: expected %0d actual %0d", $time, p.action, m_axis_tuser);
        end
        if (m_axis_tdata[9:0] !== p.offset) begin
          errors++;
          $display("%0t offset: expected %0d actual %0d", $time, p.offset, m_axis_tdata[9:0]);
        end
        if (m_axis_tdata[17:10] !== p.value) begin
          errors++;
          $display("%0t value: expected %h actual %h", $time, p.value, m_axis_tdata[17:10]);
        end
        if (m_axis_tlast !== p.eor) begin
          errors++;
          $display("%0t end_of_run: expected %b actual %b", $time, p.eor, m_axis_tlast);
        end
      end
    end
  end

  // one input word, held until taken
  task automatic send_word(input logic cmd, input logic [5:0] ent, input logic [7:0] cpos,
                           input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 6) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {2'b00, b, cpos, ent};
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    words_in++;
    filter_step(cmd, ent, cpos, b, last);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (patch_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_RESP_TYPE: cfg_rtype = v[1:0];
      REG_REDIR_IP:  cfg_ip    = v;
      REG_ENT_COUNT: cfg_count = v[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_entry(input int e, input string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_LOAD, e[5:0], i[7:0], s[i], 1'b0);
    send_word(CMD_LOAD, e[5:0], 8'(s.len()), 8'h00, 1'b0);
    ent_name[e] = s;
  endtask

  // dotted name to wire labels, optionally with random case and terminator
  task automatic add_name(input string s, input bit mix_case, input bit term,
                          ref logic [7:0] q [$]);
    int start;
    logic [7:0] c;
    start = 0;
    for (int i = 0; i <= s.len(); i++) begin
      if (i == s.len() || s[i] == ".") begin
        if (i > start) begin
          q.push_back(8'(i - start));
          for (int j = start; j < i; j++) begin
            c = s[j];
            if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(1)) c = c - 8'h20;
            q.push_back(c);
          end
        end
        start = i + 1;
      end
    end
    if (term) q.push_back(8'h00);
  endtask

  task automatic add_header(ref logic [7:0] q [$]);
    for (int i = 0; i < HEADER_BYTES; i++) q.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_tail(input int n, ref logic [7:0] q [$]);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
  endtask

  task automatic send_packet(ref logic [7:0] q [$]);
    foreach (q[i]) send_word(CMD_PKT, 6'($urandom_range(63)), 8'($urandom_range(255)), q[i],
                             i == q.size() - 1);
  endtask

  // short names keep every compare inside the zero-filled part of the list
  function automatic string rand_name();
    string s;
    string alpha;
    int    labels;
    alpha  = "abcdefghijklmnopqrstuvwxyz0123456789-";
    s      = "";
    labels = $urandom_range(2, 1);
    for (int l = 0; l < labels; l++) begin
      if (l > 0) s = {s, "."};
      for (int k = $urandom_range(2, 1); k > 0; k--)
        s = {s, string'(alpha[$urandom_range(alpha.len() - 1)])};
    end
    return s;
  endfunction

  pkt_row_t dir_rows [] = '{
    '{K_NAME,      "ab.cd",  1'b1, ACT_PATCH},
    '{K_NAME,      "ab.cde", 1'b1, ACT_FORWARD},
    '{K_OPEN,      "ab.cd",  1'b1, ACT_FORWARD},
    '{K_ZERO_IN,   "q",      1'b0, ACT_FORWARD},
    '{K_SHORT,     "xy",     1'b1, ACT_PATCH},
    '{K_LOAD_MID,  "m.n",    1'b0, ACT_FORWARD},
    '{K_LOAD_LAST, "q",      1'b1, ACT_PATCH}
  };

  initial begin
    logic [7:0] q [$];
    int         pick;
    int         r;
    int         pkts;
    logic [31:0] phase_cfg [3][3];

    phase_cfg[0] = '{32'd2, 32'hffff_ffff, 32'd4};
    phase_cfg[1] = '{32'd3, 32'h0000_0000, 32'd3};
    phase_cfg[2] = '{32'd0, 32'h0a0b_0c0d, 32'd2};
    phase_cfg[1][1] = $urandom();

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    words_in      = 0;
    words_out     = 0;
    blocked_pkts  = 0;
    hold_req      = 0;
    idle_on       = 1'b0;
    cfg_rtype     = 2'd1;
    cfg_ip        = '0;
    cfg_count     = '0;
    last_first_act = ACT_FORWARD;
    foreach (bl_store[e, p]) bl_store[e][p] = 8'h00;
    foreach (ent_name[e]) ent_name[e] = "";
    pkt_clear();

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // right after reset a packet that never leaves the header goes through
    q = {};
    add_header(q);
    q = q[0:4];
    send_packet(q);
    check_act("after reset", ACT_FORWARD);
    drain();

    // entry characters that can be compared get a defined value first
    for (int e = 0; e < FILL_ENTRIES; e++)
      for (int p = 0; p < FILL_CHARS; p++)
        send_word(CMD_LOAD, 6'(e), 8'(p), 8'h00, 1'b0);

    // directed part, reply type still at its reset value
    idle_on = 1'b1;
    load_entry(0, "ab.cd");
    load_entry(1, "XY");
    load_entry(2, "q");
    load_entry(3, "m.n");
    drain();
    reg_write(REG_ENT_COUNT, 32'd4);

    foreach (dir_rows[i]) begin
      q = {};
      add_header(q);
      case (dir_rows[i].kind)
        K_OPEN:     add_name(dir_rows[i].name, 1'b0, 1'b0, q);
        K_ZERO_IN: begin
          q.push_back(8'd3);
          q.push_back("q");
          q.push_back(8'h00);
          q.push_back("b");
          q.push_back(8'h00);
          add_tail(1, q);
        end
        K_SHORT:    add_name(dir_rows[i].name, 1'b0, 1'b1, q);
        default: begin
          add_name(dir_rows[i].name, 1'b0, 1'b1, q);
          add_tail(1, q);
        end
      endcase
      if (dir_rows[i].kind == K_LOAD_MID) begin
        for (int k = 0; k < q.size(); k++) begin
          if (k == 15) send_word(CMD_LOAD, 6'd62, 8'd255, 8'($urandom_range(255)), 1'b0);
          send_word(CMD_PKT, 6'd0, 8'd0, q[k], k == q.size() - 1);
        end
      end else if (dir_rows[i].kind == K_LOAD_LAST) begin
        foreach (q[k]) send_word(CMD_PKT, 6'd0, 8'd0, q[k], 1'b0);
        send_word(CMD_LOAD, 6'd62, 8'd128, 8'h7f, 1'b1);
      end else begin
        send_packet(q);
      end
      if (dir_rows[i].known) check_act($sformatf("directed row %0d", i), dir_rows[i].want_act);
    end
    drain();

    // random part: several register settings, mostly well-formed queries
    for (int ph = 0; ph < 3; ph++) begin
      reg_write(REG_RESP_TYPE, phase_cfg[ph][0]);
      reg_write(REG_REDIR_IP, phase_cfg[ph][1]);
      reg_write(REG_ENT_COUNT, phase_cfg[ph][2]);
      load_entry($urandom_range(3), rand_name());
      idle_on = (ph != 0);
      pkts = (ph == 1) ? 6 : 2;
      if (ph == 1) hold_req++;
      for (int k = 0; k < pkts; k++) begin
        q = {};
        add_header(q);
        r = $urandom_range(99);
        if (ph == 1 || r < 50) begin
          pick = $urandom_range(1);
          add_name(ent_name[pick], 1'b1, 1'b1, q);
          add_tail($urandom_range(3), q);
        end else if (r < 75) begin
          add_name(rand_name(), 1'b1, 1'b1, q);
          add_tail($urandom_range(3), q);
        end else if (r < 88) begin
          // raw noise past the header
          add_tail($urandom_range(7, 1), q);
        end else if (r < 95) begin
          add_name(ent_name[$urandom_range(3)], 1'b1, 1'b0, q);
        end else begin
          q = q[0:$urandom_range(11)];
        end
        if ($urandom_range(9) == 0)
          send_word(CMD_LOAD, 6'($urandom_range(63)), 8'(200 + $urandom_range(55)),
                    8'($urandom_range(255)), 1'b0);
        send_packet(q);
      end
      drain();
    end

    $display("sent %0d words, checked %0d results, %0d packets blocked", words_in, words_out,
             blocked_pkts);
    $display("covered each reply type, case folding, open and cut names, loads mid packet");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dqbf_pkg.sv
rtl/dqbf_ram.sv
rtl/dqbf_front.sv
rtl/dqbf_match.sv
rtl/dqbf_back.sv
rtl/dns_query_blacklist_filter.sv
verif/testbench.sv
